### rtl/core/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the lru key-value cache
// Field widths, operation codes, reset values and the slot and command
// records that pass between the cache top level and its slot cells.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // payload widths
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    // default number of slots and capacity after reset
    localparam int            DEFAULT_ENTRIES = 16;
    localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;

    // operation codes carried in func
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // contents of one slot
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot;

    // per-item command broadcast to every cell
    typedef struct packed {
        logic update;    // apply this item to the slot row
        logic hit_mode;  // shift only cells up to the matching one
        logic evict;     // least recent entry is dropped, valid bits hold
    } t_cell_cmd;

endpackage

### rtl/core/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell: one slot of the recency-ordered cache row
// Holds one key/value entry, compares it against a lookup key, takes over
// its upper neighbor's entry when the row shifts, and feeds the match,
// read and eviction chains that run through the row.
// ----------------------------------------------------------------------------
module lkvc_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // lookup, sampled when an input transfer is accepted
    input  logic                           i_lookup,
    input  logic [lkvc_pkg::KEY_W-1:0]     i_lookup_key,
    // update command for the current item
    input  lkvc_pkg::t_cell_cmd            i_cmd,
    // neighbors
    input  lkvc_pkg::t_slot                i_prev_slot,
    input  logic                           i_next_valid,
    output lkvc_pkg::t_slot                o_slot,
    // chains through the row
    input  logic                           i_found,
    output logic                           o_found,
    input  logic [lkvc_pkg::VALUE_W-1:0]   i_rd_value,
    output logic [lkvc_pkg::VALUE_W-1:0]   o_rd_value,
    input  logic [lkvc_pkg::KEY_W-1:0]     i_ev_key,
    output logic [lkvc_pkg::KEY_W-1:0]     o_ev_key
);

    logic                           r_valid;
    logic [lkvc_pkg::KEY_W-1:0]     r_key;
    logic [lkvc_pkg::VALUE_W-1:0]   r_value;
    logic                           r_match;
    logic                           n_valid;
    logic                           w_shift;
    logic                           w_last;

    // shift decision: in hit mode only cells at or above the match move
    always_comb begin
        w_shift = i_cmd.hit_mode ? !i_found : 1'b1;
        n_valid = i_cmd.evict ? (i_prev_slot.valid & r_valid) : i_prev_slot.valid;
        w_last  = r_valid & !i_next_valid;
    end

    // valid bit and match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_cmd.update && w_shift) begin
                r_valid <= n_valid;
            end
            if (i_lookup) begin
                r_match <= r_valid && (r_key == i_lookup_key);
            end
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && w_shift) begin
            r_key   <= i_prev_slot.key;
            r_value <= i_prev_slot.value;
        end
    end

    // chain outputs, keys are unique so at most one cell contributes
    always_comb begin
        o_slot.valid = r_valid;
        o_slot.key   = r_key;
        o_slot.value = r_value;
        o_found      = i_found | r_match;
        o_rd_value   = i_rd_value | (r_match ? r_value : '0);
        o_ev_key     = i_ev_key | (w_last ? r_key : '0);
    end

endmodule

### rtl/core/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key-value cache, lru order
// A row of slot cells kept in recency order, most recent in slot 0.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: s_axis_tdata carries key and value, s_axis_tuser carries
//   func (get or put). Output stream: m_axis_tdata carries read_value and
//   evicted_key, m_axis_tuser carries hit and evicted. One result per item.
//   Capacity is written through i_cfg_wr_en / i_cfg_wr_data while idle.
//   Timing: the edge that accepts an item samples the key compare in every
//   cell; the next edge, unless the receiver stalls, applies the shift of the
//   slot row and loads the output register.
//   Flow: one item in flight at a time; the compare-then-update sequence on
//   the shared slot row must finish before the next item is accepted.
//   Reset: the cache is empty and capacity returns to 16.
//   Receiver stall: a waiting result holds in the output register; the
//   following item may still be accepted and compared, but its update and
//   result wait until the output register is taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
    parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: capacity register
    input  logic                           i_cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]     i_cfg_wr_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [63:0]                    s_axis_tdata,  // [31:0] key, [63:32] value
    input  logic [0:0]                     s_axis_tuser,  // [0] func
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [63:0]                    m_axis_tdata,  // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]                     m_axis_tuser   // [0] hit, [1] evicted
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = ((OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W) + 1;
    localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

    logic [lkvc_pkg::CAP_W-1:0]     r_capacity;
    logic [OCC_W-1:0]               r_occ;
    logic                           r_busy;
    logic                           r_func;
    logic [lkvc_pkg::KEY_W-1:0]     r_key;
    logic [lkvc_pkg::VALUE_W-1:0]   r_value;
    logic                           r_out_valid;
    logic [63:0]                    r_out_data;
    logic [1:0]                     r_out_user;

    logic                           w_accept;
    logic                           w_fire;
    logic                           w_hit;
    logic                           w_put;
    logic                           w_evict;
    logic [CMP_W-1:0]               w_cap_ext;
    logic [CMP_W-1:0]               w_cap_eff;
    logic [CMP_W-1:0]               w_occ_ext;
    lkvc_pkg::t_cell_cmd            w_cmd;

    lkvc_pkg::t_slot                w_slot   [ENTRIES+1];
    logic                           w_valid  [ENTRIES+1];
    logic                           w_found  [ENTRIES+1];
    logic [lkvc_pkg::VALUE_W-1:0]   w_rd     [ENTRIES+1];
    logic [lkvc_pkg::KEY_W-1:0]     w_ev     [ENTRIES+1];

    // handshake
    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fire        = r_busy && (!r_out_valid || m_axis_tready);

    // effective capacity saturated into 1..ENTRIES
    always_comb begin
        w_cap_ext = CMP_W'(r_capacity);
        if (w_cap_ext == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (w_cap_ext > ENTRIES_C) begin
            w_cap_eff = ENTRIES_C;
        end else begin
            w_cap_eff = w_cap_ext;
        end
        w_occ_ext = CMP_W'(r_occ);
    end

    // item decode
    always_comb begin
        w_hit          = w_found[ENTRIES];
        w_put          = (r_func == lkvc_pkg::FUNC_PUT);
        w_evict        = w_put && !w_hit && (w_occ_ext >= w_cap_eff) && (r_occ != '0);
        w_cmd.update   = w_fire && (w_hit || w_put);
        w_cmd.hit_mode = w_hit;
        w_cmd.evict    = w_evict;
    end

    // new most recent entry enters the row at slot 0
    assign w_slot[0].valid  = 1'b1;
    assign w_slot[0].key    = r_key;
    assign w_slot[0].value  = w_put ? r_value : w_rd[ENTRIES];
    assign w_found[0]       = 1'b0;
    assign w_rd[0]          = '0;
    assign w_ev[0]          = '0;
    assign w_valid[ENTRIES] = 1'b0;

    // slot row
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign w_valid[g] = w_slot[g+1].valid;

        lkvc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_lookup     (w_accept),
            .i_lookup_key (s_axis_tdata[31:0]),
            .i_cmd        (w_cmd),
            .i_prev_slot  (w_slot[g]),
            .i_next_valid (w_valid[g+1]),
            .o_slot       (w_slot[g+1]),
            .i_found      (w_found[g]),
            .o_found      (w_found[g+1]),
            .i_rd_value   (w_rd[g]),
            .o_rd_value   (w_rd[g+1]),
            .i_ev_key     (w_ev[g]),
            .o_ev_key     (w_ev[g+1])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= lkvc_pkg::CAP_RESET;
            r_occ       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_fire) begin
                r_busy <= 1'b0;
            end
            if (w_fire && w_put && !w_hit && !w_evict) begin
                r_occ <= r_occ + OCC_W'(1);
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= s_axis_tuser[0];
            r_key   <= s_axis_tdata[31:0];
            r_value <= s_axis_tdata[63:32];
        end
        if (w_fire) begin
            r_out_data[31:0]  <= (w_hit && !w_put) ? w_rd[ENTRIES] : '0;
            r_out_data[63:32] <= w_evict ? w_ev[ENTRIES] : '0;
            r_out_user[0]     <= w_hit;
            r_out_user[1]     <= w_evict;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // checks
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_occ) <= ENTRIES_C)
        else $error("occupancy beyond slot count");

    a_evict_keeps_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_evict) |=> $stable(r_occ))
        else $error("eviction changed occupancy");

    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
        else $error("result flags both hit and eviction");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (m_axis_tvalid && !r_busy))
        else $error("update did not present a result");

endmodule
